@@ hdl/taar_pkg.sv @@
package taar_pkg;

	localparam int CHILD_SLOTS_DEF = 3;

	// Result status codes.
	localparam logic [2:0] ST_GRANT   = 3'd0;
	localparam logic [2:0] ST_REFUSE  = 3'd1;
	localparam logic [2:0] ST_PARENT  = 3'd2;
	localparam logic [2:0] ST_CHILD   = 3'd3;
	localparam logic [2:0] ST_NOROUTE = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] REG_RANGE_START = 3'd0;
	localparam logic [2:0] REG_RANGE_END   = 3'd1;
	localparam logic [2:0] REG_PARENT      = 3'd2;
	localparam logic [2:0] REG_MAX_CHILD   = 3'd3;
	localparam logic [2:0] REG_MAX_ROUTER  = 3'd4;
	localparam logic [2:0] REG_MAX_DEPTH   = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_MUL,
		S_SCAN,
		S_STEP,
		S_RESP
	} taar_state_t;

endpackage

@@ hdl/taar_unit.sv @@
module taar_unit #(
	parameter int W = 11
) (
	input  logic         sub,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] res,
	output logic         borrow
);

	logic [W:0] full;

	// Subtraction is a plus the inverted b plus one; a missing carry out is a borrow.
	assign full   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{W{1'b0}}, sub};
	assign res    = full[W-1:0];
	assign borrow = sub & ~full[W];

endmodule

@@ hdl/tree_address_assign_and_route_core.sv @@
// Address block of one node in a tree network.
// Channels: an item (op, requester_addr, dest_addr) is taken at a rising edge with start
// high and busy low. Its single result is on the result ports for exactly one cycle while
// done is high; the receiver cannot stall it. busy stays high from acceptance through the
// done cycle, so the next item can be taken in the cycle after done. A new item is therefore
// never accepted while an earlier one is still being worked on.
// Configuration: cfg_index/cfg_data are written when cfg_valid and cfg_ready are high;
// cfg_ready is high while the block is idle.
// Steps from the accepting edge to the done cycle:
//   refused joins, routes to the parent and answers for the node itself: straight to done;
//   route queries inside the block: a compare, then m add/compare pairs, where m is the
//   number of segments passed over by the compare/add loop (at most CHILD_SLOTS-1);
//   granted joins for child slot k: the segment size by a constant reciprocal
//   multiplication, then k additions to place the sub-range.
// The compare and add steps share one add/subtract unit, so they take turns.
// Reset clears the configuration, the joined count and the segment size; the child
// address table is not cleared, since a slot is only read after it has been granted.
module tree_address_assign_and_route_core
	import taar_pkg::*;
#(
	parameter int CHILD_SLOTS = CHILD_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [15:0] requester_addr,
	input  logic [7:0]  dest_addr,
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] next_hop_addr,
	output logic [1:0]  child_slot,
	output logic [7:0]  child_range_start,
	output logic [7:0]  child_range_end,
	output logic [7:0]  grant_max_children,
	output logic [7:0]  grant_max_routers,
	output logic [7:0]  grant_max_depth,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int SW = $clog2(CHILD_SLOTS + 1);
	localparam int IW = $clog2(CHILD_SLOTS);
	localparam int AW = 8 + SW;
	localparam int DIV_SH  = 8 + $clog2(CHILD_SLOTS);
	localparam int DIV_MUL = (2 ** DIV_SH + CHILD_SLOTS - 1) / CHILD_SLOTS;
	localparam int PW      = DIV_SH + 8;

	taar_state_t state_q, state_d;

	logic [7:0]  range_start_q, range_end_q, max_child_q, max_router_q, max_depth_q;
	logic [15:0] parent_q;
	logic [SW-1:0] joined_q;
	logic [7:0]  seg_q;
	logic [15:0] child_tab_q [CHILD_SLOTS];

	logic [15:0] req_q;
	logic [7:0]  off_q;
	logic [7:0]  quo_q;
	logic [AW-1:0] acc_q;
	logic [IW-1:0] k_q;

	logic [2:0]  status_q;
	logic [15:0] next_hop_q;
	logic [1:0]  slot_q;
	logic [7:0]  crs_q, cre_q, gmc_q, gmr_q, gmd_q;

	logic          u_sub;
	logic [AW-1:0] u_a, u_b, u_res;
	logic          u_borrow;
	logic [PW-1:0] quo_prod;
	logic          accept, grant_ok, outside, at_last, more, present;
	logic [SW-1:0] k_ext;
	logic [7:0]    k_wide;

	taar_unit #(.W(AW)) u_unit (
		.sub    (u_sub),
		.a      (u_a),
		.b      (u_b),
		.res    (u_res),
		.borrow (u_borrow)
	);

	assign accept   = start && (state_q == S_IDLE);
	// The rounded-up reciprocal of the slot count gives the exact quotient for
	// every 8-bit block width.
	assign quo_prod = PW'(quo_q) * PW'(DIV_MUL);
	assign grant_ok = (range_end_q > range_start_q) && (joined_q < SW'(CHILD_SLOTS));
	assign outside  = (dest_addr < range_start_q) || (dest_addr > range_end_q);
	assign k_ext    = SW'(k_q);
	assign k_wide   = 8'(k_q);
	assign at_last  = (k_ext == joined_q);
	assign present  = (k_ext < joined_q);
	// In the scan the unit computes threshold minus offset; a borrow means the
	// destination lies beyond the current slot's segment.
	assign more     = (k_ext < SW'(CHILD_SLOTS - 1)) && u_borrow;

	always_comb begin
		u_sub = 1'b0;
		u_a   = '0;
		u_b   = '0;
		case (state_q)
			S_MUL: begin
				u_a = acc_q;
				u_b = AW'(quo_q);
			end
			S_SCAN: begin
				u_sub = 1'b1;
				u_a   = acc_q;
				u_b   = AW'(off_q);
			end
			S_STEP: begin
				u_a = acc_q;
				u_b = AW'(seg_q);
			end
			default: begin
				u_sub = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!op) begin
						state_d = grant_ok ? S_DIV : S_RESP;
					end else if (outside || (dest_addr == range_start_q)) begin
						state_d = S_RESP;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_DIV: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				if (at_last) begin
					state_d = S_RESP;
				end
			end
			S_SCAN: begin
				state_d = more ? S_STEP : S_RESP;
			end
			S_STEP: begin
				state_d = S_SCAN;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy      = (state_q != S_IDLE);
		cfg_ready = (state_q == S_IDLE);
		done      = (state_q == S_RESP);
	end

	assign status             = status_q;
	assign next_hop_addr      = next_hop_q;
	assign child_slot         = slot_q;
	assign child_range_start  = crs_q;
	assign child_range_end    = cre_q;
	assign grant_max_children = gmc_q;
	assign grant_max_routers  = gmr_q;
	assign grant_max_depth    = gmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			joined_q      <= '0;
			seg_q         <= '0;
			range_start_q <= '0;
			range_end_q   <= '0;
			parent_q      <= '0;
			max_child_q   <= '0;
			max_router_q  <= '0;
			max_depth_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_RANGE_START: range_start_q <= cfg_data[7:0];
					REG_RANGE_END:   range_end_q   <= cfg_data[7:0];
					REG_PARENT:      parent_q      <= cfg_data;
					REG_MAX_CHILD:   max_child_q   <= cfg_data[7:0];
					REG_MAX_ROUTER:  max_router_q  <= cfg_data[7:0];
					REG_MAX_DEPTH:   max_depth_q   <= cfg_data[7:0];
					default: begin
					end
				endcase
			end
			if ((state_q == S_MUL) && at_last) begin
				joined_q <= joined_q + SW'(1);
				seg_q    <= quo_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q  <= requester_addr;
					off_q  <= dest_addr - range_start_q;
					k_q    <= '0;
					acc_q  <= op ? AW'(seg_q) : AW'(range_start_q);
					quo_q  <= range_end_q - range_start_q;
					status_q   <= op ? (outside ? ST_PARENT : ST_NOROUTE) : ST_REFUSE;
					next_hop_q <= (op && outside) ? parent_q : 16'd0;
					slot_q <= 2'd0;
					crs_q  <= 8'd0;
					cre_q  <= 8'd0;
					gmc_q  <= 8'd0;
					gmr_q  <= 8'd0;
					gmd_q  <= 8'd0;
				end
			end
			S_DIV: begin
				quo_q <= quo_prod[DIV_SH +: 8];
			end
			S_MUL: begin
				if (at_last) begin
					child_tab_q[k_q] <= req_q;
					status_q <= ST_GRANT;
					slot_q   <= k_wide[1:0];
					crs_q    <= acc_q[7:0] + 8'd1;
					cre_q    <= acc_q[7:0] + quo_q;
					gmc_q    <= max_child_q;
					gmr_q    <= max_router_q;
					gmd_q    <= max_depth_q;
				end else begin
					acc_q <= u_res;
					k_q   <= k_q + IW'(1);
				end
			end
			S_SCAN: begin
				if (!more) begin
					status_q   <= present ? ST_CHILD : ST_NOROUTE;
					next_hop_q <= present ? child_tab_q[k_q] : 16'd0;
					slot_q     <= k_wide[1:0];
				end
			end
			S_STEP: begin
				acc_q <= u_res;
				k_q   <= k_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

	a_joined_bound: assert property (@(posedge clk) disable iff (!arst_n)
		joined_q <= SW'(CHILD_SLOTS))
		else $error("joined count exceeds the slot count");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not make the block busy");

	a_grant_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == ST_GRANT)) |-> (joined_q == $past(joined_q) + SW'(1)))
		else $error("grant without a joined count increment");

	a_route_present: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status_q == ST_CHILD)) |-> (k_ext < joined_q))
		else $error("route to a child slot that has not joined");

endmodule
